### sv/cbie_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the CBOR item head encoder.
// No dependencies; every other file of the block refers to this package.
package cbie_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_CAPACITY = 1'b0;

   localparam logic [3:0] REQ_UINT  = 4'd0;
   localparam logic [3:0] REQ_INT   = 4'd1;
   localparam logic [3:0] REQ_BYTES = 4'd2;
   localparam logic [3:0] REQ_TEXT  = 4'd3;
   localparam logic [3:0] REQ_ARRAY = 4'd4;
   localparam logic [3:0] REQ_MAP   = 4'd5;
   localparam logic [3:0] REQ_TAG   = 4'd6;
   localparam logic [3:0] REQ_BOOL  = 4'd7;
   localparam logic [3:0] REQ_NULL  = 4'd8;
   localparam logic [3:0] REQ_FLOAT = 4'd9;
   localparam logic [3:0] REQ_RAW   = 4'd10;

   localparam logic [2:0] MAJOR_UINT   = 3'd0;
   localparam logic [2:0] MAJOR_NINT   = 3'd1;
   localparam logic [2:0] MAJOR_SIMPLE = 3'd7;

   localparam logic [4:0] AI_ONE_BYTE    = 5'd24;
   localparam logic [4:0] AI_TWO_BYTES   = 5'd25;
   localparam logic [4:0] AI_FOUR_BYTES  = 5'd26;
   localparam logic [4:0] AI_EIGHT_BYTES = 5'd27;
   localparam logic [4:0] SIMPLE_FALSE   = 5'd20;
   localparam logic [4:0] SIMPLE_TRUE    = 5'd21;
   localparam logic [4:0] SIMPLE_NULL    = 5'd22;

   localparam logic [7:0] LEAD_HALF   = 8'hf9;
   localparam logic [7:0] LEAD_SINGLE = 8'hfa;
   localparam logic [7:0] LEAD_DOUBLE = 8'hfb;

   localparam logic [3:0] NB_ZERO  = 4'd0;
   localparam logic [3:0] NB_ONE   = 4'd1;
   localparam logic [3:0] NB_TWO   = 4'd2;
   localparam logic [3:0] NB_FOUR  = 4'd4;
   localparam logic [3:0] NB_EIGHT = 4'd8;

   typedef struct packed {
      logic [3:0]  req_type;
      logic [63:0] item_value;
   } cbie_req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [31:0] byte_index;
      logic        stored;
      logic        overflow;
      logic        last_byte;
   } cbie_rsp_type;

   // One classified item: the lead byte and the argument bytes that follow it.
   typedef struct packed {
      logic [7:0]  lead;
      logic [63:0] arg;
      logic [3:0]  nbytes;
   } cbie_head_type;

endpackage

### sv/cbie_front.sv
`timescale 1ns / 1ps
// Front end: accepts request beats and classifies each into a head entry.
// Depends on cbie_pkg.
module cbie_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  cbie_pkg::cbie_req_type req_data,
   output logic                   head_valid,
   output cbie_pkg::cbie_head_type head_data,
   input  logic                   head_full
);

   localparam logic [10:0] E_MAX       = 11'h7ff;
   localparam logic [10:0] E_SINGLE_LO = 11'd897;
   localparam logic [10:0] E_SINGLE_HI = 11'd1150;
   localparam logic [10:0] E_HALF_LO   = 11'd1009;
   localparam logic [10:0] E_HALF_HI   = 11'd1038;
   localparam logic [10:0] E_SUB_LO    = 11'd874;
   localparam logic [10:0] E_SUB_HI    = 11'd896;
   localparam logic [10:0] E_SINGLE_BIAS = 11'd896;
   localparam logic [10:0] E_HALF_BIAS   = 11'd1008;
   localparam logic [10:0] E_SUB_SHIFT   = 11'd926;

   logic                    valid_ff, valid_in;
   cbie_pkg::cbie_head_type entry_ff, entry_in;
   cbie_pkg::cbie_head_type cls;
   logic                    known;
   logic                    accept;

   logic        sgn;
   logic [10:0] e;
   logic [51:0] m;
   logic [52:0] sig;
   logic [5:0]  sh;
   logic [52:0] lowmask;
   logic [22:0] subfm;
   logic [7:0]  fe;
   logic [4:0]  hexp;

   function automatic cbie_pkg::cbie_head_type make_head(input logic [2:0] major,
                                                         input logic [63:0] value);
      cbie_pkg::cbie_head_type h;
      h.arg = value;
      if (value < 64'd24) begin
         h.lead   = {major, value[4:0]};
         h.nbytes = cbie_pkg::NB_ZERO;
      end else if (value[63:8] == '0) begin
         h.lead   = {major, cbie_pkg::AI_ONE_BYTE};
         h.nbytes = cbie_pkg::NB_ONE;
      end else if (value[63:16] == '0) begin
         h.lead   = {major, cbie_pkg::AI_TWO_BYTES};
         h.nbytes = cbie_pkg::NB_TWO;
      end else if (value[63:32] == '0) begin
         h.lead   = {major, cbie_pkg::AI_FOUR_BYTES};
         h.nbytes = cbie_pkg::NB_FOUR;
      end else begin
         h.lead   = {major, cbie_pkg::AI_EIGHT_BYTES};
         h.nbytes = cbie_pkg::NB_EIGHT;
      end
      return h;
   endfunction

   always_comb begin
      sgn     = req_data.item_value[63];
      e       = req_data.item_value[62:52];
      m       = req_data.item_value[51:0];
      sig     = {1'b1, m};
      fe      = 8'(e - E_SINGLE_BIAS);
      hexp    = 5'(e - E_HALF_BIAS);
      sh      = 6'(E_SUB_SHIFT - e);
      lowmask = (53'd1 << sh) - 53'd1;
      subfm   = 23'(sig >> sh);
   end

   always_comb begin
      cls    = '0;
      known  = 1'b1;
      case (req_data.req_type)
         cbie_pkg::REQ_UINT: begin
            cls = make_head(cbie_pkg::MAJOR_UINT, req_data.item_value);
         end
         cbie_pkg::REQ_INT: begin
            if (sgn) cls = make_head(cbie_pkg::MAJOR_NINT, ~req_data.item_value);
            else cls = make_head(cbie_pkg::MAJOR_UINT, req_data.item_value);
         end
         cbie_pkg::REQ_BYTES, cbie_pkg::REQ_TEXT, cbie_pkg::REQ_ARRAY,
         cbie_pkg::REQ_MAP, cbie_pkg::REQ_TAG: begin
            cls = make_head(req_data.req_type[2:0], req_data.item_value);
         end
         cbie_pkg::REQ_BOOL: begin
            cls.lead = {cbie_pkg::MAJOR_SIMPLE,
                        req_data.item_value[0] ? cbie_pkg::SIMPLE_TRUE
                                               : cbie_pkg::SIMPLE_FALSE};
         end
         cbie_pkg::REQ_NULL: begin
            cls.lead = {cbie_pkg::MAJOR_SIMPLE, cbie_pkg::SIMPLE_NULL};
         end
         cbie_pkg::REQ_RAW: begin
            cls.lead = req_data.item_value[7:0];
         end
         cbie_pkg::REQ_FLOAT: begin
            cls.lead   = cbie_pkg::LEAD_DOUBLE;
            cls.nbytes = cbie_pkg::NB_EIGHT;
            cls.arg    = req_data.item_value;
            if (e == E_MAX) begin
               if (m == '0) begin
                  cls.lead   = cbie_pkg::LEAD_SINGLE;
                  cls.nbytes = cbie_pkg::NB_FOUR;
                  cls.arg    = {32'd0, sgn, 8'hff, 23'd0};
               end
            end else if (e == '0) begin
               if (m == '0) begin
                  cls.lead   = cbie_pkg::LEAD_HALF;
                  cls.nbytes = cbie_pkg::NB_TWO;
                  cls.arg    = {48'd0, sgn, 15'd0};
               end
            end else if (e >= E_SINGLE_LO && e <= E_SINGLE_HI && m[28:0] == '0) begin
               if (e >= E_HALF_LO && e <= E_HALF_HI && m[41:29] == '0) begin
                  cls.lead   = cbie_pkg::LEAD_HALF;
                  cls.nbytes = cbie_pkg::NB_TWO;
                  cls.arg    = {48'd0, sgn, hexp, m[51:42]};
               end else begin
                  cls.lead   = cbie_pkg::LEAD_SINGLE;
                  cls.nbytes = cbie_pkg::NB_FOUR;
                  cls.arg    = {32'd0, sgn, fe, m[51:29]};
               end
            end else if (e >= E_SUB_LO && e <= E_SUB_HI && (sig & lowmask) == '0) begin
               cls.lead   = cbie_pkg::LEAD_SINGLE;
               cls.nbytes = cbie_pkg::NB_FOUR;
               cls.arg    = {32'd0, sgn, 8'd0, subfm};
            end
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   assign req_full = valid_ff & head_full;
   assign accept   = req_push & ~req_full;

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (accept) begin
         valid_in = known;
         entry_in = cls;
      end else if (valid_ff & ~head_full) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign head_valid = valid_ff;
   assign head_data  = entry_ff;

endmodule

### sv/cbie_queue.sv
`timescale 1ns / 1ps
// Short register queue of classified head entries between front and back.
// Depends on cbie_pkg.
module cbie_queue #(
   parameter int DEPTH = cbie_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_valid,
   input  cbie_pkg::cbie_head_type wr_data,
   output logic                    wr_full,
   output logic                    rd_valid,
   output cbie_pkg::cbie_head_type rd_data,
   input  logic                    rd_pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cbie_pkg::cbie_head_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign wr_full  = (count_ff == FULL_CNT);
   assign rd_valid = (count_ff != '0);
   assign rd_data  = entries_ff[rd_ptr_ff];
   assign do_wr    = wr_valid & ~wr_full;
   assign do_rd    = rd_pop & rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_rd) rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (do_wr & ~do_rd) count_in = count_ff + 1'b1;
      else if (do_rd & ~do_wr) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) entries_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

### sv/cbie_back.sv
`timescale 1ns / 1ps
// Back end: serializes head entries into byte beats, keeps the byte count
// and the sticky overflow flag, and holds the result register. Depends on cbie_pkg.
module cbie_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  cbie_pkg::cbie_head_type head_data,
   output logic                    head_pop,
   input  logic [31:0]             capacity,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output cbie_pkg::cbie_rsp_type  rsp_data
);

   logic                    busy_ff, busy_in;
   logic [3:0]              pos_ff, pos_in;
   cbie_pkg::cbie_head_type cur_ff;
   logic [31:0]             count_ff, count_in;
   logic                    overflow_ff, overflow_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   cbie_pkg::cbie_rsp_type  rsp_ff, rsp_in;

   logic        out_free, adv, last;
   logic [2:0]  sel;
   logic [63:0] shifted;
   logic        st;

   assign out_free = ~rsp_valid_ff | rsp_pop;
   assign adv      = busy_ff & out_free;
   assign last     = (pos_ff == cur_ff.nbytes);
   assign head_pop = head_valid & (~busy_ff | (adv & last));
   assign sel      = 3'(cur_ff.nbytes - pos_ff);
   assign shifted  = cur_ff.arg >> {sel, 3'b000};
   assign st       = (count_ff < capacity);

   always_comb begin
      busy_in      = busy_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_pop) rsp_valid_in = 1'b0;
      if (adv) begin
         pos_in            = pos_ff + 1'b1;
         overflow_in       = overflow_ff | ~st;
         count_in          = (count_ff == '1) ? count_ff : count_ff + 1'b1;
         rsp_valid_in      = 1'b1;
         rsp_in.out_byte   = (pos_ff == '0) ? cur_ff.lead : shifted[7:0];
         rsp_in.byte_index = count_ff;
         rsp_in.stored     = st;
         rsp_in.overflow   = overflow_ff | ~st;
         rsp_in.last_byte  = last;
         if (last) busy_in = 1'b0;
      end
      if (head_pop) begin
         busy_in = 1'b1;
         pos_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pos_ff       <= '0;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (head_pop) cur_ff <= head_data;
      rsp_ff <= rsp_in;
   end

   assign rsp_empty = ~rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> pos_ff <= cur_ff.nbytes)
      else $error("byte position ran past the head length");
   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !out_free |=> $stable(pos_ff) && $stable(count_ff))
      else $error("serializer advanced while the result register was blocked");
   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |=> overflow_ff)
      else $error("overflow flag cleared");
   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      adv && count_ff != 32'hffffffff |=> count_ff == $past(count_ff) + 32'd1)
      else $error("byte count did not step with an emitted beat");
`endif

endmodule

### sv/cbor_item_head_encoder.sv
`timescale 1ns / 1ps
// Top level of the CBOR item head encoder: configuration register, front end,
// head queue and back end. Depends on cbie_pkg, cbie_front, cbie_queue, cbie_back.

// Each request beat carries one CBOR data item and produces its deterministic
// encoding (shortest for integer arguments) as one to nine result beats, one
// byte per beat, with last_byte set on the final one; unknown request types
// produce nothing. The back end emits one byte per cycle while its result
// register is empty or being popped, so a run of items streams without gaps,
// while the front end and the head queue take further requests. Each byte carries
// its position from a saturating 32-bit count and is marked stored when that
// position is below buffer_capacity (register at byte address 0); a byte that is
// not stored sets the sticky overflow flag, which only reset clears.
module cbor_item_head_encoder #(
   parameter int QUEUE_DEPTH = cbie_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  cbie_pkg::cbie_req_type            req_data,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output cbie_pkg::cbie_rsp_type            rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cbie_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cbie_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cbie_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   logic [31:0]             capacity_ff, capacity_in;
   logic                    csr_write;
   logic                    front_valid, queue_full;
   cbie_pkg::cbie_head_type front_data;
   logic                    queue_valid, queue_pop;
   cbie_pkg::cbie_head_type queue_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == cbie_pkg::CSR_CAPACITY) ? capacity_ff : '0;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_write && csr_paddr[2] == cbie_pkg::CSR_CAPACITY) capacity_in = csr_pwdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= '0;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   cbie_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .head_valid (front_valid),
      .head_data  (front_data),
      .head_full  (queue_full)
   );

   cbie_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_data  (front_data),
      .wr_full  (queue_full),
      .rd_valid (queue_valid),
      .rd_data  (queue_data),
      .rd_pop   (queue_pop)
   );

   cbie_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (queue_valid),
      .head_data  (queue_data),
      .head_pop   (queue_pop),
      .capacity   (capacity_ff),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule
